FILE: rtl/rgba_pixel_blend_into_framebuffer_core_defines.svh
// assertion macros for the pixel blend core
`ifndef RGBA_PIXEL_BLEND_INTO_FRAMEBUFFER_CORE_DEFINES_SVH
`define RGBA_PIXEL_BLEND_INTO_FRAMEBUFFER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RPBF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpbf same-cycle check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RPBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpbf next-cycle check failed");

`endif

FILE: rtl/rpbf_pkg.sv
// shared types, constants and field helpers of the pixel blend core
`default_nettype none

package rpbf_pkg;

  localparam int CoordBits  = 13;
  localparam int LineWidthW = 14;
  localparam int DepthW     = 6;
  localparam int FieldW     = 9;
  localparam int ChanW      = 8;
  localparam int WordW      = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 14;
  localparam int RowW       = CoordBits + 1;
  localparam int ProdW      = RowW + LineWidthW;
  localparam int LinW       = ProdW + 1;
  localparam int BppW       = DepthW - 3;
  localparam int OffW       = LinW + BppW;

  localparam logic [ChanW-1:0]  AlphaOpaque = 8'hff;
  localparam logic [ChanW-1:0]  AlphaClear  = 8'h00;
  localparam logic [DepthW-1:0] Depth16     = 6'd16;
  localparam logic [DepthW-1:0] Depth32     = 6'd32;
  localparam logic [WordW-1:0]  Low16Mask   = 32'h0000_ffff;

  localparam logic [DepthW-1:0]     PixelDepthRst  = 6'd32;
  localparam logic [FieldW-1:0]     RedFieldRst    = 9'd264;
  localparam logic [FieldW-1:0]     GreenFieldRst  = 9'd136;
  localparam logic [FieldW-1:0]     BlueFieldRst   = 9'd8;
  localparam logic [FieldW-1:0]     TranspFieldRst = 9'd0;
  localparam logic [LineWidthW-1:0] LineWidthRst   = 14'd640;
  localparam logic [CoordBits-1:0]  StartXRst      = '0;
  localparam logic [CoordBits-1:0]  StartYRst      = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelDepth  = 3'd0,
    CfgRedField    = 3'd1,
    CfgGreenField  = 3'd2,
    CfgBlueField   = 3'd3,
    CfgTranspField = 3'd4,
    CfgLineWidth   = 3'd5,
    CfgStartX      = 3'd6,
    CfgStartY      = 3'd7
  } cfg_idx_e;

  // load enables of the two blend stages
  typedef struct packed {
    logic s2;
    logic s3;
  } mix_en_t;

  // field length, clamped to a full channel
  function automatic logic [3:0] fld_len(input logic [FieldW-1:0] f);
    return (f[3:0] > 4'd8) ? 4'd8 : f[3:0];
  endfunction

  function automatic logic [4:0] fld_off(input logic [FieldW-1:0] f);
    return f[8:4];
  endfunction

  // keep the top bits of a channel and move them to the field position
  function automatic logic [WordW-1:0] pack_chan(input logic [FieldW-1:0] f,
                                                 input logic [ChanW-1:0]  v);
    logic [ChanW-1:0] c;
    c = v >> (4'd8 - fld_len(f));
    return {24'b0, c} << fld_off(f);
  endfunction

  // pull one channel out of a word, the other two color masks cleared first
  function automatic logic [ChanW-1:0] unpack_chan(input logic [WordW-1:0]  px,
                                                   input logic [FieldW-1:0] f,
                                                   input logic [FieldW-1:0] o1,
                                                   input logic [FieldW-1:0] o2);
    logic [WordW-1:0] m;
    logic [WordW-1:0] v;
    m = pack_chan(o1, AlphaOpaque) | pack_chan(o2, AlphaOpaque);
    v = (px & ~m) >> fld_off(f);
    return ChanW'(v[ChanW-1:0] << (4'd8 - fld_len(f)));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rpbf_if.sv
// valid/ready stream interfaces for source pixels and framebuffer writes
`default_nettype none

interface rpbf_in_if;
  logic                               valid;
  logic                               ready;
  logic [rpbf_pkg::ChanW-1:0]         src_red;
  logic [rpbf_pkg::ChanW-1:0]         src_green;
  logic [rpbf_pkg::ChanW-1:0]         src_blue;
  logic [rpbf_pkg::ChanW-1:0]         src_alpha;
  logic                               has_alpha;
  logic [rpbf_pkg::WordW-1:0]         dest_pixel;
  logic [rpbf_pkg::CoordBits-1:0]     x_pos;
  logic [rpbf_pkg::CoordBits-1:0]     y_pos;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha, has_alpha, dest_pixel,
           x_pos, y_pos,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha, has_alpha, dest_pixel,
           x_pos, y_pos,
    output ready
  );
endinterface

interface rpbf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       write_enable;
  logic [rpbf_pkg::WordW-1:0] pixel_value;
  logic [rpbf_pkg::WordW-1:0] byte_offset;

  modport source (
    output valid, write_enable, pixel_value, byte_offset,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_value, byte_offset,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/rpbf_chan_mix.sv
// one color channel of the alpha blend, two register stages
`default_nettype none

module rpbf_chan_mix (
  input  wire logic                       clk_i,
  input  wire rpbf_pkg::mix_en_t          en_i,
  input  wire logic [rpbf_pkg::ChanW-1:0] new_i,
  input  wire logic [rpbf_pkg::ChanW-1:0] old_i,
  input  wire logic [rpbf_pkg::ChanW-1:0] alpha_i,
  output      logic [rpbf_pkg::ChanW-1:0] mix_o
);

  logic [2*rpbf_pkg::ChanW-1:0] prod_new_q, prod_new_d;
  logic [2*rpbf_pkg::ChanW-1:0] prod_old_q, prod_old_d;
  logic [2*rpbf_pkg::ChanW-1:0] sum;
  logic [rpbf_pkg::ChanW-1:0]   mix_q, mix_d;

  always_comb begin
    prod_new_d = {{rpbf_pkg::ChanW{1'b0}}, new_i} * {{rpbf_pkg::ChanW{1'b0}}, alpha_i};
    prod_old_d = {{rpbf_pkg::ChanW{1'b0}}, old_i}
               * {{rpbf_pkg::ChanW{1'b0}}, (rpbf_pkg::AlphaOpaque - alpha_i)};
  end

  // the two weights add up to 255, so the sum stays within 16 bits
  assign sum   = prod_new_q + prod_old_q;
  assign mix_d = sum[2*rpbf_pkg::ChanW-1:rpbf_pkg::ChanW];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_new_q <= prod_new_d;
      prod_old_q <= prod_old_d;
    end
    if (en_i.s3) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

`default_nettype wire

FILE: rtl/rgba_pixel_blend_into_framebuffer_core.sv
// top level of the pixel blend core: config registers and four-stage pipeline
// each input transfer yields one result, registered at the end of stage 4
// throughput: one pixel per clock while the sink is ready; the ready chain lets any stage fill a bubble
// stages: decode and unpack, multiply, sum and add, pack and scale by bytes/pixel
// reset: clears stage valid bits and loads the format registers (32 bpp rgb888)
`default_nettype none
`include "rgba_pixel_blend_into_framebuffer_core_defines.svh"

module rgba_pixel_blend_into_framebuffer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rpbf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rpbf_pkg::CfgDataW-1:0] cfg_data_i,
  rpbf_in_if.sink                            pix_i,
  rpbf_out_if.source                         res_o
);

  localparam int CW = rpbf_pkg::ChanW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [rpbf_pkg::DepthW-1:0]     pixel_depth_q;
  logic [rpbf_pkg::FieldW-1:0]     red_field_q, green_field_q, blue_field_q;
  logic [rpbf_pkg::FieldW-1:0]     transp_field_q;
  logic [rpbf_pkg::LineWidthW-1:0] line_width_q;
  logic [rpbf_pkg::CoordBits-1:0]  start_x_q, start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_depth_q  <= rpbf_pkg::PixelDepthRst;
      red_field_q    <= rpbf_pkg::RedFieldRst;
      green_field_q  <= rpbf_pkg::GreenFieldRst;
      blue_field_q   <= rpbf_pkg::BlueFieldRst;
      transp_field_q <= rpbf_pkg::TranspFieldRst;
      line_width_q   <= rpbf_pkg::LineWidthRst;
      start_x_q      <= rpbf_pkg::StartXRst;
      start_y_q      <= rpbf_pkg::StartYRst;
    end else if (cfg_we_i) begin
      unique case (rpbf_pkg::cfg_idx_e'(cfg_idx_i))
        rpbf_pkg::CfgPixelDepth:  pixel_depth_q  <= cfg_data_i[rpbf_pkg::DepthW-1:0];
        rpbf_pkg::CfgRedField:    red_field_q    <= cfg_data_i[rpbf_pkg::FieldW-1:0];
        rpbf_pkg::CfgGreenField:  green_field_q  <= cfg_data_i[rpbf_pkg::FieldW-1:0];
        rpbf_pkg::CfgBlueField:   blue_field_q   <= cfg_data_i[rpbf_pkg::FieldW-1:0];
        rpbf_pkg::CfgTranspField: transp_field_q <= cfg_data_i[rpbf_pkg::FieldW-1:0];
        rpbf_pkg::CfgLineWidth:   line_width_q   <= cfg_data_i[rpbf_pkg::LineWidthW-1:0];
        rpbf_pkg::CfgStartX:      start_x_q      <= cfg_data_i[rpbf_pkg::CoordBits-1:0];
        rpbf_pkg::CfgStartY:      start_y_q      <= cfg_data_i[rpbf_pkg::CoordBits-1:0];
      endcase
    end
  end

  logic depth16, depth_ok;
  assign depth16  = (pixel_depth_q == rpbf_pkg::Depth16);
  assign depth_ok = depth16 || (pixel_depth_q == rpbf_pkg::Depth32);

  // ---------------------------------------------------------------------------
  // stage valid bits and the ready chain, a stage loads when empty or draining
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: classify alpha, unpack destination channels, row index
  // ---------------------------------------------------------------------------
  logic [rpbf_pkg::WordW-1:0] dest;
  logic                       opaque, skip, tr_path;
  logic [CW-1:0]              dr_d, dg_d, db_d;

  always_comb begin
    dest    = depth16 ? (pix_i.dest_pixel & rpbf_pkg::Low16Mask) : pix_i.dest_pixel;
    opaque  = !pix_i.has_alpha || (pix_i.src_alpha == rpbf_pkg::AlphaOpaque);
    skip    = !opaque && (pix_i.src_alpha == rpbf_pkg::AlphaClear);
    tr_path = !opaque && !skip && (rpbf_pkg::fld_len(transp_field_q) != 4'd0);
    dr_d    = rpbf_pkg::unpack_chan(dest, red_field_q, blue_field_q, green_field_q);
    dg_d    = rpbf_pkg::unpack_chan(dest, green_field_q, red_field_q, blue_field_q);
    db_d    = rpbf_pkg::unpack_chan(dest, blue_field_q, red_field_q, green_field_q);
  end

  logic [CW-1:0]                  r1_q, g1_q, b1_q, a1_q, dr1_q, dg1_q, db1_q;
  logic                           we1_q, blend1_q, tr1_q;
  logic [rpbf_pkg::RowW-1:0]      row1_q;
  logic [rpbf_pkg::CoordBits-1:0] x1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q     <= pix_i.src_red;
      g1_q     <= pix_i.src_green;
      b1_q     <= pix_i.src_blue;
      a1_q     <= pix_i.src_alpha;
      dr1_q    <= dr_d;
      dg1_q    <= dg_d;
      db1_q    <= db_d;
      we1_q    <= depth_ok && !skip;
      blend1_q <= !opaque && !skip && !tr_path;
      tr1_q    <= tr_path;
      row1_q   <= {1'b0, pix_i.y_pos} + {1'b0, start_y_q};
      x1_q     <= pix_i.x_pos;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2 and 3: per-channel blend; row times line width, then add column
  // ---------------------------------------------------------------------------
  rpbf_pkg::mix_en_t mix_en;
  logic [CW-1:0]     mix_r, mix_g, mix_b;

  assign mix_en = '{s2: en2, s3: en3};

  rpbf_chan_mix u_mix_r (
    .clk_i, .en_i(mix_en), .new_i(r1_q), .old_i(dr1_q), .alpha_i(a1_q), .mix_o(mix_r)
  );
  rpbf_chan_mix u_mix_g (
    .clk_i, .en_i(mix_en), .new_i(g1_q), .old_i(dg1_q), .alpha_i(a1_q), .mix_o(mix_g)
  );
  rpbf_chan_mix u_mix_b (
    .clk_i, .en_i(mix_en), .new_i(b1_q), .old_i(db1_q), .alpha_i(a1_q), .mix_o(mix_b)
  );

  logic [CW-1:0]              r2_q, g2_q, b2_q, a2_q, r3_q, g3_q, b3_q, a3_q;
  logic                       we2_q, blend2_q, tr2_q, we3_q, blend3_q, tr3_q;
  logic [rpbf_pkg::ProdW-1:0] rowprod2_q;
  logic [rpbf_pkg::RowW-1:0]  col2_q;
  logic [rpbf_pkg::LinW-1:0]  lin3_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      r2_q       <= r1_q;
      g2_q       <= g1_q;
      b2_q       <= b1_q;
      a2_q       <= a1_q;
      we2_q      <= we1_q;
      blend2_q   <= blend1_q;
      tr2_q      <= tr1_q;
      rowprod2_q <= rpbf_pkg::ProdW'(row1_q) * rpbf_pkg::ProdW'(line_width_q);
      col2_q     <= {1'b0, x1_q} + {1'b0, start_x_q};
    end
    if (en3) begin
      r3_q     <= r2_q;
      g3_q     <= g2_q;
      b3_q     <= b2_q;
      a3_q     <= a2_q;
      we3_q    <= we2_q;
      blend3_q <= blend2_q;
      tr3_q    <= tr2_q;
      lin3_q   <= {1'b0, rowprod2_q} + rpbf_pkg::LinW'(col2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: pick blended or source channels, pack, scale offset by bytes/pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0]                cr, cg, cb;
  logic [rpbf_pkg::WordW-1:0]   px_d;
  logic [rpbf_pkg::BppW-1:0]    bpp;
  logic [rpbf_pkg::OffW-1:0]    off_d;

  always_comb begin
    cr   = blend3_q ? mix_r : r3_q;
    cg   = blend3_q ? mix_g : g3_q;
    cb   = blend3_q ? mix_b : b3_q;
    px_d = rpbf_pkg::pack_chan(red_field_q, cr)
         | rpbf_pkg::pack_chan(green_field_q, cg)
         | rpbf_pkg::pack_chan(blue_field_q, cb);
    if (tr3_q) begin
      px_d = px_d | rpbf_pkg::pack_chan(transp_field_q, a3_q);
    end
    if (!we3_q) begin
      px_d = '0;
    end else if (depth16) begin
      px_d = px_d & rpbf_pkg::Low16Mask;
    end
    bpp   = pixel_depth_q[rpbf_pkg::DepthW-1:3];
    off_d = rpbf_pkg::OffW'(lin3_q) * rpbf_pkg::OffW'(bpp);
  end

  logic                       we4_q;
  logic [rpbf_pkg::WordW-1:0] px4_q, off4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      we4_q  <= we3_q;
      px4_q  <= px_d;
      off4_q <= rpbf_pkg::WordW'(off_d);
    end
  end

  assign res_o.valid        = v4_q;
  assign res_o.write_enable = we4_q;
  assign res_o.pixel_value  = px4_q;
  assign res_o.byte_offset  = off4_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a skipped write carries a zero word
  `RPBF_ASSERT_SAME(a_skip_zero, v4_q && !we4_q, px4_q == '0)
  // an input transfer always lands in stage 1
  `RPBF_ASSERT_NEXT(a_in_lands, pix_i.valid && pix_i.ready, v1_q)
  // a stalled multiply stage keeps its item
  `RPBF_ASSERT_NEXT(a_s2_hold, v2_q && !en3, v2_q)
  // with the sink ready, a full stage 3 reaches the output next cycle
  `RPBF_ASSERT_NEXT(a_s3_drain, v3_q && res_o.ready, v4_q)

endmodule

`default_nettype wire
